### sv/sha1md_pkg.sv
package sha1md_pkg;

    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 64;
    localparam int BLOCK_BYTES = 64;
    localparam int LEN_POS     = 56;
    localparam int ROUNDS      = 80;
    localparam int SCHED_DEPTH = 16;
    localparam int DIGEST_WORDS = 5;

    localparam int CNT_W   = $clog2(BLOCK_BYTES);
    localparam int ROUND_W = $clog2(ROUNDS);
    localparam int IDX_W   = $clog2(DIGEST_WORDS);

    localparam logic [BYTE_W-1:0]  PAD_BYTE  = 8'h80;
    localparam logic [CNT_W-1:0]   LAST_BYTE = CNT_W'(BLOCK_BYTES - 1);
    localparam logic [CNT_W-1:0]   LEN_START = CNT_W'(LEN_POS);
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
    localparam logic [IDX_W-1:0]   LAST_WORD = IDX_W'(DIGEST_WORDS - 1);

    // Schedule taps of w[t+16] = rotl1(w[t+13] ^ w[t+8] ^ w[t+2] ^ w[t])
    localparam int TAP_A = 13;
    localparam int TAP_B = 8;
    localparam int TAP_C = 2;
    localparam int TAP_D = 0;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] t_chain;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    // Control from the sequencer to the round unit
    typedef struct packed {
        logic                init;
        logic                load;
        logic                step;
        logic                add;
        logic [ROUND_W-1:0]  round;
    } t_round_ctl;

    function automatic t_word round_k(input logic [ROUND_W-1:0] t);
        t_word k;
        if (t < ROUND_W'(20)) begin
            k = 32'h5a827999;
        end else if (t < ROUND_W'(40)) begin
            k = 32'h6ed9eba1;
        end else if (t < ROUND_W'(60)) begin
            k = 32'h8f1bbcdc;
        end else begin
            k = 32'hca62c1d6;
        end
        return k;
    endfunction

    function automatic t_chain init_chain();
        t_chain c;
        c[0] = 32'h67452301;
        c[1] = 32'hEFCDAB89;
        c[2] = 32'h98BADCFE;
        c[3] = 32'h10325476;
        c[4] = 32'hc3d2e1f0;
        return c;
    endfunction

endpackage

### sv/sha1md_if.sv
interface sha1md_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

interface sha1md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;

    modport source (output valid, output digest_word, output word_number,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_number,
                    input last_word, output ready);
endinterface

### sv/sha1md_cell.sv
module sha1md_cell
    import sha1md_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_word i_d,
    output t_word o_q
);

    t_word r_q;

    // Take the neighbor's word on every shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

### sv/sha1md_round.sv
module sha1md_round
    import sha1md_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_round_ctl i_ctl,
    input  t_word      i_w,
    output t_chain     o_chain
);

    t_chain r_chain;
    t_word  r_a, r_b, r_c, r_d, r_e;
    t_word  f;
    t_word  n_a;

    // Select the round function by round range
    always_comb begin
        if (i_ctl.round inside {[0:19]}) begin
            f = (r_b & r_c) | (~r_b & r_d);
        end else if (i_ctl.round inside {[40:59]}) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
        end else begin
            f = r_b ^ r_c ^ r_d;
        end
        n_a = {r_a[26:0], r_a[31:27]} + f + r_e + round_k(i_ctl.round) + i_w;
    end

    // Working variables: load from the chain, then advance one round a cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_ctl.step) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= n_a;
        end
    end

    // Chaining words: start values, or fold in the finished block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= init_chain();
        end else if (i_ctl.init) begin
            r_chain <= init_chain();
        end else if (i_ctl.add) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
            r_chain[4] <= r_chain[4] + r_e;
        end
    end

    assign o_chain = r_chain;

endmodule

### sv/sha1_message_digest_top.sv
// SHA-1 digest engine fed one message byte per transaction. While gathering
// a block it takes one byte per cycle; bytes are packed into words that
// shift through a row of sixteen 32-bit cells, which then serve as the
// rolling message schedule. Each full 64-byte block stops input while
// its 80 rounds run at one per cycle in the single round unit and the
// result is folded into the chaining words. An end-of-message mark
// starts padding, which pushes one pad byte per cycle outside compression
// (0x80, zero fill, the 64-bit big-endian bit length) through the same
// path, with a pause where the length field starts, so finishing costs
// one or two compressions. The five digest words, most significant first,
// then leave one per cycle as the sink accepts them, and the engine returns
// to the standard start values for the next message.
// Input is not ready during compression, padding and digest output.
module sha1_message_digest_top
    import sha1md_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha1md_in_if.sink     i_in,
    sha1md_out_if.source  o_out
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_byte_cnt, n_byte_cnt;
    logic [23:0]        r_acc, n_acc;
    logic [LEN_W-1:0]   r_bit_count, n_bit_count;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [ROUND_W-1:0] r_round, n_round;
    logic [IDX_W-1:0]   r_out_idx, n_out_idx;
    logic               r_pad_pend, n_pad_pend;
    logic               r_in_zero, n_in_zero;
    logic               r_len_done, n_len_done;

    logic               in_acc;
    logic               out_acc;
    logic               push;
    logic [BYTE_W-1:0]  push_byte;
    logic               shift;
    t_word              sched_word;
    t_word              cell_in;
    t_round_ctl         ctl;
    t_chain             chain;
    t_word              q [SCHED_DEPTH];

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    // Schedule row: shift on each packed word and on each round
    genvar g;
    generate
        for (g = 0; g < SCHED_DEPTH; g++) begin : g_cell
            t_word d;
            if (g == SCHED_DEPTH - 1) begin : g_tail
                assign d = cell_in;
            end else begin : g_mid
                assign d = q[g+1];
            end
            sha1md_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_d     (d),
                .o_q     (q[g])
            );
        end
    endgenerate

    always_comb begin
        sched_word = q[TAP_A] ^ q[TAP_B] ^ q[TAP_C] ^ q[TAP_D];
        sched_word = {sched_word[30:0], sched_word[31]};
    end

    sha1md_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_w     (q[0]),
        .o_chain (chain)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.byte_present && r_byte_cnt == LAST_BYTE) begin
                        n_state = ST_ROUND;
                    end else if (i_in.end_of_message) begin
                        n_state = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK: begin
                n_state = (r_byte_cnt == LAST_BYTE) ? ST_ROUND : ST_PAD_ZERO;
            end
            ST_PAD_ZERO: begin
                if (r_byte_cnt == LEN_START) begin
                    n_state = ST_PAD_LEN;
                end else if (r_byte_cnt == LAST_BYTE) begin
                    n_state = ST_ROUND;
                end
            end
            ST_PAD_LEN: begin
                if (r_byte_cnt == LAST_BYTE) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_round == LAST_ROUND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (r_len_done) begin
                    n_state = ST_OUT;
                end else if (r_in_zero) begin
                    n_state = ST_PAD_ZERO;
                end else if (r_pad_pend) begin
                    n_state = ST_PAD_MARK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_acc && r_out_idx == LAST_WORD) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        push      = 1'b0;
        push_byte = '0;
        case (r_state)
            ST_IDLE: begin
                push      = in_acc && i_in.byte_present;
                push_byte = i_in.data_byte;
            end
            ST_PAD_MARK: begin
                push      = 1'b1;
                push_byte = PAD_BYTE;
            end
            ST_PAD_ZERO: begin
                push      = (r_byte_cnt != LEN_START);
                push_byte = '0;
            end
            ST_PAD_LEN: begin
                push      = 1'b1;
                push_byte = r_len[LEN_W-1 -: BYTE_W];
            end
            default: begin
                push      = 1'b0;
                push_byte = '0;
            end
        endcase

        ctl.init  = out_acc && r_out_idx == LAST_WORD;
        ctl.load  = push && r_byte_cnt == LAST_BYTE;
        ctl.step  = (r_state == ST_ROUND);
        ctl.add   = (r_state == ST_ADD);
        ctl.round = r_round;

        shift   = (push && r_byte_cnt[1:0] == 2'b11) || ctl.step;
        cell_in = ctl.step ? sched_word : {r_acc, push_byte};

        i_in.ready        = (r_state == ST_IDLE);
        o_out.valid       = (r_state == ST_OUT);
        o_out.digest_word = chain[r_out_idx];
        o_out.word_number = r_out_idx;
        o_out.last_word   = (r_out_idx == LAST_WORD);
    end

    // Next values of counters, flags and pad data
    always_comb begin
        n_byte_cnt  = r_byte_cnt;
        n_acc       = r_acc;
        n_bit_count = r_bit_count;
        n_len       = r_len;
        n_round     = r_round;
        n_out_idx   = r_out_idx;
        n_pad_pend  = r_pad_pend;
        n_in_zero   = r_in_zero;
        n_len_done  = r_len_done;

        if (push) begin
            n_byte_cnt = r_byte_cnt + 1'b1;
            n_acc      = {r_acc[15:0], push_byte};
        end
        if (r_state == ST_IDLE && push) begin
            n_bit_count = r_bit_count + LEN_W'(BYTE_W);
        end
        if (r_state == ST_IDLE && in_acc && i_in.end_of_message) begin
            n_pad_pend = 1'b1;
        end
        // Capture the bit length as the pad mark goes in
        if (r_state == ST_PAD_MARK) begin
            n_pad_pend = 1'b0;
            n_in_zero  = 1'b1;
            n_len      = r_bit_count;
        end
        if (r_state == ST_PAD_ZERO && r_byte_cnt == LEN_START) begin
            n_in_zero = 1'b0;
        end
        if (r_state == ST_PAD_LEN) begin
            n_len = {r_len[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            if (r_byte_cnt == LAST_BYTE) begin
                n_len_done = 1'b1;
            end
        end
        if (ctl.step) begin
            n_round = (r_round == LAST_ROUND) ? '0 : r_round + 1'b1;
        end
        // Step through the digest words; clear message state after the last
        if (out_acc) begin
            if (r_out_idx == LAST_WORD) begin
                n_out_idx   = '0;
                n_len_done  = 1'b0;
                n_bit_count = '0;
            end else begin
                n_out_idx = r_out_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_byte_cnt  <= '0;
            r_bit_count <= '0;
            r_round     <= '0;
            r_out_idx   <= '0;
            r_pad_pend  <= 1'b0;
            r_in_zero   <= 1'b0;
            r_len_done  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_byte_cnt  <= n_byte_cnt;
            r_bit_count <= n_bit_count;
            r_round     <= n_round;
            r_out_idx   <= n_out_idx;
            r_pad_pend  <= n_pad_pend;
            r_in_zero   <= n_in_zero;
            r_len_done  <= n_len_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_len <= n_len;
    end

    // A compression only starts on a full block
    a_round_on_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_byte_cnt == '0))
        else $error("compression running on a partial block");

    // The round counter is back at zero once the chain is folded
    a_round_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |-> (r_round == '0))
        else $error("round counter out of step with the sequencer");

    // The last digest transaction leaves the engine ready and cleared
    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.last_word) |=>
            (i_in.ready && r_bit_count == '0 && r_byte_cnt == '0))
        else $error("engine not cleared after the digest");

    // Digest is only shown after the length bytes went in
    a_out_after_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_len_done && !r_pad_pend && !r_in_zero))
        else $error("digest shown before padding finished");

endmodule

### verif/sha1_message_digest_top_tb.sv
`timescale 1ns / 100ps

module sha1_message_digest_top_tb
    import sha1md_pkg::*;
();

    localparam int HOLD_MAX    = 18;
    localparam int ITEM_TARGET = 430;
    // Worst quiet stretch: the pad bytes, two compressions and five receiver
    // stalls come to well under this limit.
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 300;
    localparam int FINAL_IDX   = 4;

    localparam logic [31:0] K_00_19 = 32'h5a827999;
    localparam logic [31:0] K_20_39 = 32'h6ed9eba1;
    localparam logic [31:0] K_40_59 = 32'h8f1bbcdc;
    localparam logic [31:0] K_60_79 = 32'hca62c1d6;

    localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         eom;
        logic         known;
        logic [159:0] digest;
    } t_stim_row;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  num;
        logic        last;
    } t_digest_word;

    // Directed transactions; a typed digest is used where one is well known
    localparam t_stim_row DIR_ROWS [13] = '{
        '{8'hA5, 1'b0, 1'b0, 1'b0, 160'h0},          // idle step, no effect
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},    // empty message
        '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},      // "abc", end mark on last byte
        '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h5A, 1'b0, 1'b0, 1'b0, 160'h0},          // idle step mid-message
        '{8'hFF, 1'b0, 1'b1, 1'b0, 160'h0},          // end mark alone, byte ignored
        '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},          // single byte 0xFF
        '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},          // single byte 0x00
        '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},    // empty again after re-init
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
    };

    logic i_clk;
    logic i_rst_n;

    sha1md_in_if  in_if ();
    sha1md_out_if out_if ();

    sha1_message_digest_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predictor state
    logic [31:0] hash_h [5];
    logic [7:0]  msg_blk [64];
    logic [5:0]  blk_fill;
    logic [63:0] msg_bits;

    t_digest_word digest_q [$];
    int           mismatches = 0;
    int           msg_items  = 0;
    bit           send_fast  = 1'b0;
    int           idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void digest_reinit();
        hash_h[0] = 32'h67452301;
        hash_h[1] = 32'hEFCDAB89;
        hash_h[2] = 32'h98BADCFE;
        hash_h[3] = 32'h10325476;
        hash_h[4] = 32'hC3D2E1F0;
        blk_fill  = '0;
        msg_bits  = '0;
    endfunction

    // Run the 80 rounds over msg_blk and fold into the chaining words
    function automatic void sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                w[t] = {msg_blk[4*t], msg_blk[4*t+1], msg_blk[4*t+2], msg_blk[4*t+3]};
            end else begin
                w[t % 16] = rol(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16]
                                ^ w[t % 16], 1);
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_00_19;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_20_39;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_40_59;
            end else begin
                f = b ^ c ^ d;
                k = K_60_79;
            end
            tmp = rol(a, 5) + f + e + k + w[t % 16];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = tmp;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endfunction

    // Advance the predictor by one transaction; returns 1 when a digest is due
    function automatic bit digest_step(input logic [7:0] b, input logic p, input logic e,
                                       output logic [159:0] dig);
        int          i;
        logic [63:0] total;
        dig = '0;
        if (p) begin
            msg_blk[blk_fill] = b;
            blk_fill = blk_fill + 6'd1;
            if (blk_fill == '0) begin
                sha1_compress();
                msg_bits += 64'd512;
            end
        end
        if (!e) begin
            return 1'b0;
        end
        // Pad: marker byte, zero fill, big-endian bit length
        i = int'(blk_fill);
        total = msg_bits + 64'(blk_fill) * 64'd8;
        msg_blk[i] = 8'h80;
        i++;
        if (i > 56) begin
            while (i < 64) begin
                msg_blk[i] = 8'h00;
                i++;
            end
            sha1_compress();
            i = 0;
        end
        while (i < 56) begin
            msg_blk[i] = 8'h00;
            i++;
        end
        for (int j = 0; j < 8; j++) begin
            msg_blk[63 - j] = total[8*j +: 8];
        end
        sha1_compress();
        dig = {hash_h[0], hash_h[1], hash_h[2], hash_h[3], hash_h[4]};
        digest_reinit();
        return 1'b1;
    endfunction

    // Drive one transaction, wait for acceptance, then queue the expected words
    task automatic send_item(input logic [7:0] b, input logic p, input logic e,
                             input logic known = 1'b0, input logic [159:0] known_digest = '0);
        int           gap;
        logic [159:0] dig;
        t_digest_word wexp;
        gap = send_fast ? 0 : $urandom_range(0, HOLD_MAX);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.data_byte      <= b;
        in_if.byte_present   <= p;
        in_if.end_of_message <= e;
        do @(posedge i_clk); while (!in_if.ready);
        msg_items++;
        if (digest_step(b, p, e, dig)) begin
            if (known) begin
                dig = known_digest;
            end
            for (int j = 0; j <= FINAL_IDX; j++) begin
                wexp.word = dig[159 - 32*j -: 32];
                wexp.num  = 3'(j);
                wexp.last = (j == FINAL_IDX);
                digest_q.push_back(wexp);
            end
        end
    endtask

    // Send a message of len bytes with random content, noise and end mark
    task automatic send_message(input int len);
        bit mark_on_byte;
        mark_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        send_fast = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(8'($urandom), 1'b1, mark_on_byte && (k == len - 1));
        end
        if (!mark_on_byte) begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // Stimulus
    initial begin
        int len;
        int boundary [9];
        boundary = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.data_byte      <= '0;
        in_if.byte_present   <= 1'b0;
        in_if.end_of_message <= 1'b0;
        digest_reinit();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (DIR_ROWS[r]) begin
            send_item(DIR_ROWS[r].data, DIR_ROWS[r].present, DIR_ROWS[r].eom,
                      DIR_ROWS[r].known, DIR_ROWS[r].digest);
        end

        // Random messages, biased toward short ones and the padding boundaries
        while (msg_items < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(0, 8);
                4, 5:       len = $urandom_range(9, 50);
                6, 7:       len = boundary[$urandom_range(0, 8)];
                8:          len = $urandom_range(51, 70);
                default:    len = $urandom_range(100, 140);
            endcase
            // Keep the last message within the transaction budget
            if (len > ITEM_TARGET - msg_items) begin
                len = ITEM_TARGET - msg_items;
            end
            send_message(len);
        end
        in_if.valid <= 1'b0;

        // Drain outstanding digest words, then hold off for stray output
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("sha1_message_digest_top: match");
        end else begin
            $display("sha1_message_digest_top: mismatch");
        end
        $finish;
    end

    // Result side: random backpressure, compare against the oldest expectation
    initial begin
        int           stall;
        int           run_left;
        bit           recv_fast;
        t_digest_word wexp;
        run_left  = 0;
        recv_fast = 1'b0;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (run_left == 0) begin
                recv_fast = ($urandom_range(0, 3) == 0);
                run_left  = $urandom_range(5, 20);
            end
            run_left--;
            stall = recv_fast ? 0 : $urandom_range(0, HOLD_MAX);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            if (digest_q.size() == 0) begin
                $error("unexpected digest_word %h word_number %0d",
                       out_if.digest_word, out_if.word_number);
                mismatches++;
            end else begin
                wexp = digest_q.pop_front();
                if (out_if.digest_word !== wexp.word) begin
                    $error("digest_word: expected %h, actual %h", wexp.word,
                           out_if.digest_word);
                    mismatches++;
                end
                if (out_if.word_number !== wexp.num) begin
                    $error("word_number: expected %0d, actual %0d", wexp.num,
                           out_if.word_number);
                    mismatches++;
                end
                if (out_if.last_word !== wexp.last) begin
                    $error("last_word: expected %b, actual %b", wexp.last,
                           out_if.last_word);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("sha1_message_digest_top: mismatch");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
